[rtl/core/ncss_pkg.sv]
package ncss_pkg;

   localparam int DEF_POINTS  = 8;
   localparam int DEF_CENTERS = 1024;

   localparam int COORD_W = 16;
   localparam int LIMIT_W = 11;
   localparam int SCORE_W = 34;
   localparam int LABEL_W = 11;

   // Largest possible mean: three axes of full-scale difference.
   localparam logic [SCORE_W-1:0] SCORE_MAX = 34'd12884508675;

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_QUERY = 2'd1,
      CMD_CLEAR = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_ISSUE  = 2'd1,
      ST_DRAIN  = 2'd2,
      ST_DIVIDE = 2'd3
   } state_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } point_type;

   typedef struct packed {
      logic [1:0]                cmd;
      logic signed [COORD_W-1:0] coord_x;
      logic signed [COORD_W-1:0] coord_y;
      logic signed [COORD_W-1:0] coord_z;
   } req_type;

   typedef struct packed {
      logic [SCORE_W-1:0] score;
      logic [LABEL_W-1:0] label;
      logic               no_centers;
   } rsp_type;

   // Control that travels with each center down the chain.
   typedef struct packed {
      logic valid;
      logic last;
   } tok_type;

endpackage

[rtl/core/ncss_ram.sv]
module ncss_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

[rtl/core/ncss_cell.sv]
module ncss_cell import ncss_pkg::*; #(
   parameter int CENTERS = DEF_CENTERS,
   parameter int AW      = 10,
   parameter int SUM_W   = 37
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             c_we,
   input  logic [AW-1:0]    c_waddr,
   input  point_type        c_wdata,
   input  logic             q_we,
   input  point_type        q_wdata,
   input  tok_type          tok_i,
   input  logic [AW-1:0]    idx_i,
   input  logic [SUM_W-1:0] sum_i,
   output tok_type          tok_o,
   output logic [AW-1:0]    idx_o,
   output logic [SUM_W-1:0] sum_o
);

   point_type        qpt_ff;
   point_type        cpt;
   tok_type          t1_ff, t2_ff, t3_ff, t4_ff;
   logic [AW-1:0]    i1_ff, i2_ff, i3_ff, i4_ff;
   logic [SUM_W-1:0] s1_ff, s2_ff, s3_ff, s4_ff;
   logic signed [COORD_W:0]     dx_ff, dy_ff, dz_ff;
   logic signed [2*COORD_W+1:0] px, py, pz;
   logic [2*COORD_W-1:0]        qx_ff, qy_ff, qz_ff;
   logic [SUM_W-1:0]            s4_in;

   // This cell's slice of the center table: point p of every center.
   ncss_ram #(.WIDTH($bits(point_type)), .DEPTH(CENTERS)) u_bank (
      .clock(clock),
      .we   (c_we),
      .waddr(c_waddr),
      .wdata(c_wdata),
      .raddr(idx_i),
      .rdata(cpt)
   );

   assign px = dx_ff * dx_ff;
   assign py = dy_ff * dy_ff;
   assign pz = dz_ff * dz_ff;
   assign s4_in = s3_ff + SUM_W'(qx_ff) + SUM_W'(qy_ff) + SUM_W'(qz_ff);

   always_ff @(posedge clock) begin
      if (q_we) begin
         qpt_ff <= q_wdata;
      end
      i1_ff <= idx_i;
      s1_ff <= sum_i;
      i2_ff <= i1_ff;
      s2_ff <= s1_ff;
      dx_ff <= {qpt_ff.x[COORD_W-1], qpt_ff.x} - {cpt.x[COORD_W-1], cpt.x};
      dy_ff <= {qpt_ff.y[COORD_W-1], qpt_ff.y} - {cpt.y[COORD_W-1], cpt.y};
      dz_ff <= {qpt_ff.z[COORD_W-1], qpt_ff.z} - {cpt.z[COORD_W-1], cpt.z};
      i3_ff <= i2_ff;
      s3_ff <= s2_ff;
      qx_ff <= px[2*COORD_W-1:0];
      qy_ff <= py[2*COORD_W-1:0];
      qz_ff <= pz[2*COORD_W-1:0];
      i4_ff <= i3_ff;
      s4_ff <= s4_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_ff <= '0;
         t2_ff <= '0;
         t3_ff <= '0;
         t4_ff <= '0;
      end else begin
         t1_ff <= tok_i;
         t2_ff <= t1_ff;
         t3_ff <= t2_ff;
         t4_ff <= t3_ff;
      end
   end

   assign tok_o = t4_ff;
   assign idx_o = i4_ff;
   assign sum_o = s4_ff;

endmodule

[rtl/core/nearest_center_streamline_scorer.sv]
// Load, clear and non-final query words are taken one per cycle while busy is low and give no result.
// A final query word with no centers in use gives its result on the next cycle.
// With centers in use the result strobe follows the final query word once the center
// indices are fed through the cell chain, the mean is divided and the result registered.
// busy is high during the search; the receiver cannot stall the result strobe.
// Reset (synchronous, active high) empties the table and query position, limit 0.
module nearest_center_streamline_scorer import ncss_pkg::*; #(
   parameter int POINTS  = DEF_POINTS,
   parameter int CENTERS = DEF_CENTERS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  req_type            req_data,
   output logic               rsp_valid,
   output rsp_type            rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [LIMIT_W-1:0] csr_data
);

   // Widths that follow from the table shape.
   localparam int AW    = (CENTERS > 1) ? $clog2(CENTERS) : 1;
   localparam int CNT_W = $clog2(CENTERS + 1);
   localparam int PPW   = (POINTS > 1) ? $clog2(POINTS) : 1;
   localparam int SUM_W = SCORE_W + $clog2(POINTS);
   localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

   // The mean is taken as a multiply by the rounded-up reciprocal of the point count.
   // With a dividend below 2**SUM_W the scaled product floors to the exact quotient.
   // The constant is split in two halves so that each partial product stays small.
   localparam int PSH    = (POINTS > 1) ? $clog2(POINTS) : 0;
   localparam int SH     = SUM_W + PSH;
   localparam int MW     = SUM_W + 1;
   localparam int MH     = (MW + 1) / 2;
   localparam int PROD_W = SUM_W + MW;
   localparam logic [63:0] RECIP = ((64'd1 << SH) + 64'(POINTS - 1)) / 64'(POINTS);

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   loaded_ff, loaded_in;
   logic [PPW-1:0]     lpos_ff, lpos_in;
   logic [PPW-1:0]     qpos_ff, qpos_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic [CNT_W-1:0]   inuse_ff, inuse_in;
   logic [CNT_W-1:0]   issue_ff, issue_in;
   logic [SUM_W-1:0]   best_ff, best_in;
   logic [AW-1:0]      bidx_ff, bidx_in;
   logic [SUM_W-1:0]   quo_ff, quo_in;
   logic               dcnt_ff, dcnt_in;
   logic [SUM_W+MH-1:0]    plo_ff, plo_in;
   logic [SUM_W+MW-MH-1:0] phi_ff, phi_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               accept;
   logic               table_full;
   logic [CMP_W-1:0]   loaded_x, limit_x;
   logic [CNT_W-1:0]   inuse_now;
   logic               better;
   logic [PROD_W-1:0]  prod;
   point_type          pt;

   tok_type            tok [POINTS+1];
   logic [AW-1:0]      idx [POINTS+1];
   logic [SUM_W-1:0]   sum [POINTS+1];

   assign accept     = start && !busy;
   assign busy       = (state_ff != ST_IDLE);
   assign csr_ready  = 1'b1;
   assign table_full = (loaded_ff == CNT_W'(CENTERS));
   assign pt         = '{x: req_data.coord_x, y: req_data.coord_y, z: req_data.coord_z};

   // The count in use is the limit when it is set and below the loaded count.
   assign loaded_x  = CMP_W'(loaded_ff);
   assign limit_x   = CMP_W'(limit_ff);
   assign inuse_now = ((limit_x != '0) && (limit_x < loaded_x)) ? CNT_W'(limit_x) : loaded_ff;

   // Feed of the chain: one center index a cycle, the final one flagged.
   assign tok[0] = '{valid: (state_ff == ST_ISSUE), last: (issue_ff == inuse_ff - 1'b1)};
   assign idx[0] = issue_ff[AW-1:0];
   assign sum[0] = '0;

   // Each cell owns one point of the streamline: its bank of center points and the
   // matching query point. A partial sum rides with every center index down the chain.
   for (genvar p = 0; p < POINTS; p++) begin : g_cell
      ncss_cell #(.CENTERS(CENTERS), .AW(AW), .SUM_W(SUM_W)) u_cell (
         .clock  (clock),
         .reset  (reset),
         .c_we   (accept && (cmd_type'(req_data.cmd) == CMD_LOAD) && !table_full
                  && (lpos_ff == PPW'(p))),
         .c_waddr(loaded_ff[AW-1:0]),
         .c_wdata(pt),
         .q_we   (accept && (cmd_type'(req_data.cmd) == CMD_QUERY)
                  && (qpos_ff == PPW'(p))),
         .q_wdata(pt),
         .tok_i  (tok[p]),
         .idx_i  (idx[p]),
         .sum_i  (sum[p]),
         .tok_o  (tok[p+1]),
         .idx_o  (idx[p+1]),
         .sum_o  (sum[p+1])
      );
   end

   // The first center always takes the lead; later ones only when strictly smaller.
   assign better  = (idx[POINTS] == '0) || (sum[POINTS] < best_ff);

   // Partial products of the winning sum with the two reciprocal halves, then their sum.
   assign plo_in = (SUM_W+MH)'(quo_ff) * (SUM_W+MH)'(RECIP[MH-1:0]);
   assign phi_in = (SUM_W+MW-MH)'(quo_ff) * (SUM_W+MW-MH)'(RECIP[MW-1:MH]);
   assign prod   = (PROD_W'(phi_ff) << MH) + PROD_W'(plo_ff);

   always_comb begin
      state_in     = state_ff;
      loaded_in    = loaded_ff;
      lpos_in      = lpos_ff;
      qpos_in      = qpos_ff;
      limit_in     = limit_ff;
      inuse_in     = inuse_ff;
      issue_in     = issue_ff;
      best_in      = best_ff;
      bidx_in      = bidx_ff;
      quo_in       = quo_ff;
      dcnt_in      = dcnt_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      if (csr_valid && csr_ready) begin
         limit_in = csr_data;
      end

      if (tok[POINTS].valid && better) begin
         best_in = sum[POINTS];
         bidx_in = idx[POINTS];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_data.cmd)
                  CMD_LOAD: begin
                     if (!table_full) begin
                        if (lpos_ff == PPW'(POINTS - 1)) begin
                           lpos_in   = '0;
                           loaded_in = loaded_ff + 1'b1;
                        end else begin
                           lpos_in = lpos_ff + 1'b1;
                        end
                     end
                  end
                  CMD_CLEAR: begin
                     loaded_in = '0;
                     lpos_in   = '0;
                  end
                  CMD_QUERY: begin
                     if (qpos_ff == PPW'(POINTS - 1)) begin
                        qpos_in = '0;
                        if (inuse_now == '0) begin
                           rsp_valid_in = 1'b1;
                           rsp_in       = '{score: SCORE_MAX, label: '0, no_centers: 1'b1};
                        end else begin
                           inuse_in = inuse_now;
                           issue_in = '0;
                           state_in = ST_ISSUE;
                        end
                     end else begin
                        qpos_in = qpos_ff + 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ISSUE: begin
            issue_in = issue_ff + 1'b1;
            if (tok[0].last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (tok[POINTS].valid && tok[POINTS].last) begin
               quo_in   = better ? sum[POINTS] : best_ff;
               bidx_in  = better ? idx[POINTS] : bidx_ff;
               dcnt_in  = 1'b0;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            // The partial products are registered first; then they are added and shifted into the result.
            dcnt_in = 1'b1;
            if (dcnt_ff) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{score: prod[SH +: SCORE_W],
                                label: LABEL_W'((AW+1)'(bidx_ff) + 1'b1),
                                no_centers: 1'b0};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         loaded_ff    <= '0;
         lpos_ff      <= '0;
         qpos_ff      <= '0;
         limit_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         loaded_ff    <= loaded_in;
         lpos_ff      <= lpos_in;
         qpos_ff      <= qpos_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      inuse_ff <= inuse_in;
      issue_ff <= issue_in;
      best_ff  <= best_in;
      bidx_ff  <= bidx_in;
      quo_ff   <= quo_in;
      dcnt_ff  <= dcnt_in;
      plo_ff   <= plo_in;
      phi_ff   <= phi_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[rtl/core/ncss_checker.sv]
module ncss_checker import ncss_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input req_type            req_data,
   input logic               rsp_valid,
   input rsp_type            rsp_data,
   input logic               csr_valid,
   input logic               csr_ready,
   input logic [LIMIT_W-1:0] csr_data
);

   // An empty search reports the saturated score and no label.
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.no_centers |->
         (rsp_data.label == '0) && (rsp_data.score == SCORE_MAX))
      else $error("empty search result malformed");

   // A real match always names a center.
   a_label: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.no_centers |-> (rsp_data.label != '0))
      else $error("match without label");

   // The end of a search is marked by its result word.
   a_done: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $fell(busy) |-> rsp_valid && !rsp_data.no_centers)
      else $error("search ended without result");

   // busy never rises without a start word before it.
   a_start: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy without start");

endmodule

bind nearest_center_streamline_scorer ncss_checker u_ncss_checker (.*);
